/* rtl/core/sbd_pkg.sv */
// Shared constants and types of the sparse bit dictionary.
`default_nettype none
package sbd_pkg;
    localparam int unsigned DEPTH = 1024;
    localparam int unsigned IDX_W = 10;
    localparam int unsigned USED_W = 11;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned OCC_W = 24;
    localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

    typedef enum logic [1:0] {
        OP_PROFILE = 2'd0,
        OP_CONVERT = 2'd1,
        OP_PRUNE   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic [OCC_W-1:0] occ;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_ctl_t;
endpackage
`default_nettype wire

/* rtl/core/sbd_entry_ram.sv */
// Entry memory: one write and one registered read port.
`default_nettype none
module sbd_entry_ram (
    input  wire             aclk,
    input  sbd_pkg::ram_ctl_t ctl,
    output sbd_pkg::entry_t rdata
);
    sbd_pkg::entry_t mem [sbd_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata <= mem[ctl.raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/sparse_bit_dictionary_top.sv */
// Top level of the sparse bit dictionary.
//
// Input channel s_*: one request per item (profile, convert or prune).
// Result channel m_*: exactly one result per request, in order.
// Config channel cfg_*: writes prune_threshold; always ready. The user must
// see that it is written only while the block is idle; the block does not enforce it.
// Operation: a lookup scans the entry memory, reading and then comparing
// each stored entry in turn. Prune compacts the table and, if anything
// was removed, selection-sorts the survivors in the memory. All of this
// goes through the single read port of the entry memory.
// One request is in work at a time; the next request is taken as soon
// as the previous result sits in the output register, even if the
// receiver stalls. A result waits for m_ready while the next is computed.
// Reset (aresetn low, synchronous) empties the dictionary, clears the
// extra totals and the threshold; memory contents are not cleared since
// entries above the fill count are never read.
`default_nettype none
module sparse_bit_dictionary_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_opcode,
    input  wire  [31:0] s_bit_number,
    input  wire  [15:0] s_bit_count,
    input  wire         s_last_bit,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [9:0]  m_dense_index,
    output logic        m_found,
    output logic        m_inserted,
    output logic        m_table_full,
    output logic [15:0] m_out_count,
    output logic [15:0] m_miss_bits,
    output logic [31:0] m_miss_sum,
    output logic [10:0] m_removed,
    output logic        m_fingerprint_done
);
    typedef enum logic [3:0] {
        S_IDLE, S_LK_RD, S_LK_CMP, S_MISS, S_PC_RD, S_PC_CMP,
        S_SO_RDI, S_SO_LDI, S_SO_RDJ, S_SO_CMPJ, S_SO_SW1, S_SO_SW2, S_OUT
    } state_t;

    state_t state_reg;
    sbd_pkg::op_t op_reg;
    logic [31:0] key_reg;
    logic [15:0] cnt_reg;
    logic        last_reg;
    logic [15:0] thr_reg;
    logic [10:0] used_reg;
    logic [10:0] idx_reg;
    logic [10:0] kept_reg;
    logic [10:0] si_reg;
    logic [10:0] minpos_reg;
    sbd_pkg::entry_t min_reg;
    sbd_pkg::entry_t ient_reg;
    logic [15:0] xbits_reg;
    logic [31:0] xcnt_reg;

    // pending result
    logic [9:0]  r_idx_reg;
    logic        r_found_reg, r_ins_reg, r_full_reg, r_done_reg;
    logic [15:0] r_cnt_reg, r_xbits_reg;
    logic [31:0] r_xcnt_reg;
    logic [10:0] r_rem_reg;

    sbd_pkg::ram_ctl_t ctl;
    sbd_pkg::entry_t   rdata;

    sbd_entry_ram u_ram (.aclk(aclk), .ctl(ctl), .rdata(rdata));

    logic [32:0] xsum;
    logic [15:0] xbits_inc;
    logic [31:0] xcnt_inc;
    logic        occ_keep;

    assign xsum      = {1'b0, xcnt_reg} + {17'd0, cnt_reg};
    assign xbits_inc = (xbits_reg == 16'hFFFF) ? xbits_reg : xbits_reg + 16'd1;
    assign xcnt_inc  = xsum[32] ? 32'hFFFF_FFFF : xsum[31:0];
    assign occ_keep  = rdata.occ > {8'd0, thr_reg};

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        ctl = '0;
        ctl.raddr = idx_reg[9:0];
        case (state_reg)
            S_LK_CMP: begin
                if (rdata.key == key_reg && op_reg == sbd_pkg::OP_PROFILE) begin
                    ctl.we = 1'b1;
                    ctl.waddr = idx_reg[9:0];
                    ctl.wdata.key = rdata.key;
                    ctl.wdata.occ = (rdata.occ == sbd_pkg::OCC_MAX) ?
                                    rdata.occ : rdata.occ + 24'd1;
                end
            end
            S_MISS: begin
                if (op_reg == sbd_pkg::OP_PROFILE && !used_reg[10]) begin
                    ctl.we = 1'b1;
                    ctl.waddr = used_reg[9:0];
                    ctl.wdata.key = key_reg;
                    ctl.wdata.occ = 24'd1;
                end
            end
            S_PC_CMP: begin
                ctl.we = occ_keep;
                ctl.waddr = kept_reg[9:0];
                ctl.wdata = rdata;
            end
            S_SO_RDI: ctl.raddr = si_reg[9:0];
            S_SO_SW1: begin
                ctl.we = (minpos_reg != si_reg);
                ctl.waddr = si_reg[9:0];
                ctl.wdata = min_reg;
            end
            S_SO_SW2: begin
                ctl.we = (minpos_reg != si_reg);
                ctl.waddr = minpos_reg[9:0];
                ctl.wdata = ient_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            xbits_reg <= '0;
            xcnt_reg  <= '0;
            thr_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            // in S_OUT the output register is reloaded instead
            if (m_valid && m_ready && state_reg != S_OUT) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg   <= sbd_pkg::op_t'(s_opcode);
                        key_reg  <= s_bit_number;
                        cnt_reg  <= s_bit_count;
                        last_reg <= s_last_bit;
                        idx_reg  <= '0;
                        kept_reg <= '0;
                        r_idx_reg <= '0; r_found_reg <= 1'b0; r_ins_reg <= 1'b0;
                        r_full_reg <= 1'b0; r_done_reg <= 1'b0; r_cnt_reg <= '0;
                        r_xbits_reg <= '0; r_xcnt_reg <= '0; r_rem_reg <= '0;
                        case (sbd_pkg::op_t'(s_opcode))
                            sbd_pkg::OP_PROFILE, sbd_pkg::OP_CONVERT:
                                state_reg <= (used_reg == '0) ? S_MISS : S_LK_RD;
                            sbd_pkg::OP_PRUNE:
                                state_reg <= (thr_reg == '0 || used_reg == '0) ?
                                             S_OUT : S_PC_RD;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_LK_RD: state_reg <= S_LK_CMP;
                S_LK_CMP: begin
                    if (rdata.key == key_reg) begin
                        r_idx_reg   <= idx_reg[9:0];
                        r_found_reg <= 1'b1;
                        if (op_reg == sbd_pkg::OP_CONVERT) begin
                            r_cnt_reg   <= cnt_reg;
                            r_xbits_reg <= xbits_reg;
                            r_xcnt_reg  <= xcnt_reg;
                            r_done_reg  <= last_reg;
                            if (last_reg) begin
                                xbits_reg <= '0;
                                xcnt_reg  <= '0;
                            end
                        end
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg   <= idx_reg + 11'd1;
                        state_reg <= (idx_reg + 11'd1 == used_reg) ? S_MISS : S_LK_RD;
                    end
                end
                S_MISS: begin
                    if (op_reg == sbd_pkg::OP_PROFILE) begin
                        if (!used_reg[10]) begin
                            r_idx_reg <= used_reg[9:0];
                            r_ins_reg <= 1'b1;
                            used_reg  <= used_reg + 11'd1;
                        end else begin
                            r_full_reg <= 1'b1;
                        end
                    end else begin
                        r_xbits_reg <= xbits_inc;
                        r_xcnt_reg  <= xcnt_inc;
                        r_done_reg  <= last_reg;
                        xbits_reg   <= last_reg ? 16'd0 : xbits_inc;
                        xcnt_reg    <= last_reg ? 32'd0 : xcnt_inc;
                    end
                    state_reg <= S_OUT;
                end
                S_PC_RD: state_reg <= S_PC_CMP;
                S_PC_CMP: begin
                    if (occ_keep) begin
                        kept_reg <= kept_reg + 11'd1;
                    end
                    idx_reg <= idx_reg + 11'd1;
                    if (idx_reg + 11'd1 == used_reg) begin
                        if (occ_keep && kept_reg + 11'd1 == used_reg) begin
                            state_reg <= S_OUT;
                        end else begin
                            r_rem_reg <= used_reg - kept_reg - {10'd0, occ_keep};
                            kept_reg  <= kept_reg + {10'd0, occ_keep};
                            used_reg  <= kept_reg + {10'd0, occ_keep};
                            si_reg    <= '0;
                            state_reg <= (kept_reg + {10'd0, occ_keep} <= 11'd1) ?
                                         S_OUT : S_SO_RDI;
                        end
                    end else begin
                        state_reg <= S_PC_RD;
                    end
                end
                S_SO_RDI: state_reg <= S_SO_LDI;
                S_SO_LDI: begin
                    min_reg    <= rdata;
                    ient_reg   <= rdata;
                    minpos_reg <= si_reg;
                    idx_reg    <= si_reg + 11'd1;
                    state_reg  <= S_SO_RDJ;
                end
                S_SO_RDJ: state_reg <= S_SO_CMPJ;
                S_SO_CMPJ: begin
                    if (rdata.key < min_reg.key) begin
                        min_reg    <= rdata;
                        minpos_reg <= idx_reg;
                    end
                    idx_reg   <= idx_reg + 11'd1;
                    state_reg <= (idx_reg + 11'd1 == kept_reg) ? S_SO_SW1 : S_SO_RDJ;
                end
                S_SO_SW1: state_reg <= S_SO_SW2;
                S_SO_SW2: begin
                    si_reg    <= si_reg + 11'd1;
                    state_reg <= (si_reg + 11'd2 == kept_reg) ? S_OUT : S_SO_RDI;
                end
                S_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid            <= 1'b1;
                        m_dense_index      <= r_idx_reg;
                        m_found            <= r_found_reg;
                        m_inserted         <= r_ins_reg;
                        m_table_full       <= r_full_reg;
                        m_out_count        <= r_cnt_reg;
                        m_miss_bits        <= r_xbits_reg;
                        m_miss_sum         <= r_xcnt_reg;
                        m_removed          <= r_rem_reg;
                        m_fingerprint_done <= r_done_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the sparse bit dictionary top level.
`default_nettype none
module tb;
    // One request on the input channel.
    typedef struct {
        sbd_pkg::op_t op;
        logic [31:0]  bitn;
        logic [15:0]  cnt;
        logic         last;
    } bit_req_t;

    // One result, field by field as it leaves m_*.
    typedef struct {
        logic [9:0]  idx;
        logic        found;
        logic        inserted;
        logic        full;
        logic [15:0] out_count;
        logic [15:0] miss_bits;
        logic [31:0] miss_sum;
        logic [10:0] removed;
        logic        done;
    } dict_result_t;

    localparam int unsigned CYCLE_LIMIT = 20000000;
    localparam int unsigned SETTLE = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [31:0] s_bit_number = '0;
    logic [15:0] s_bit_count = '0;
    logic        s_last_bit = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [9:0]  m_dense_index;
    logic        m_found;
    logic        m_inserted;
    logic        m_table_full;
    logic [15:0] m_out_count;
    logic [15:0] m_miss_bits;
    logic [31:0] m_miss_sum;
    logic [10:0] m_removed;
    logic        m_fingerprint_done;

    sparse_bit_dictionary_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_bit_number(s_bit_number), .s_bit_count(s_bit_count),
        .s_last_bit(s_last_bit),
        .m_valid(m_valid), .m_ready(m_ready), .m_dense_index(m_dense_index),
        .m_found(m_found), .m_inserted(m_inserted), .m_table_full(m_table_full),
        .m_out_count(m_out_count), .m_miss_bits(m_miss_bits),
        .m_miss_sum(m_miss_sum), .m_removed(m_removed),
        .m_fingerprint_done(m_fingerprint_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow dictionary state, updated as each request is accepted.
    logic [31:0] shadow_key [sbd_pkg::DEPTH];
    logic [23:0] shadow_occ [sbd_pkg::DEPTH];
    int unsigned shadow_used = 0;
    logic [15:0] unknown_bits = '0;
    logic [31:0] unknown_sum = '0;
    logic [15:0] threshold = '0;

    bit_req_t     pending_reqs [$];
    dict_result_t expected_results [$];
    int unsigned  errors = 0;
    int unsigned  reqs_queued = 0;
    int unsigned  reqs_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  cycles = 0;
    bit           quiet = 1'b0;   // no idling on either side while set

    function automatic dict_result_t dict_apply(bit_req_t r);
        dict_result_t res;
        int          pos;
        int          kept;
        int          j;
        logic [31:0] k;
        logic [23:0] c;
        logic [32:0] sum;
        res = '{default: '0};
        pos = -1;
        if (r.op == sbd_pkg::OP_PROFILE || r.op == sbd_pkg::OP_CONVERT) begin
            for (int i = 0; i < shadow_used; i++)
                if (pos < 0 && shadow_key[i] == r.bitn) pos = i;
        end
        case (r.op)
            sbd_pkg::OP_PROFILE: begin
                if (pos >= 0) begin
                    if (shadow_occ[pos] != sbd_pkg::OCC_MAX) shadow_occ[pos]++;
                    res.idx = 10'(pos);
                    res.found = 1'b1;
                end else if (shadow_used < sbd_pkg::DEPTH) begin
                    shadow_key[shadow_used] = r.bitn;
                    shadow_occ[shadow_used] = 24'd1;
                    res.idx = 10'(shadow_used);
                    res.inserted = 1'b1;
                    shadow_used++;
                end else begin
                    res.full = 1'b1;
                end
            end
            sbd_pkg::OP_CONVERT: begin
                if (pos >= 0) begin
                    res.idx = 10'(pos);
                    res.found = 1'b1;
                    res.out_count = r.cnt;
                end else begin
                    if (unknown_bits != 16'hFFFF) unknown_bits++;
                    sum = {1'b0, unknown_sum} + {17'd0, r.cnt};
                    unknown_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                res.miss_bits = unknown_bits;
                res.miss_sum = unknown_sum;
                if (r.last) begin
                    res.done = 1'b1;
                    unknown_bits = '0;
                    unknown_sum = '0;
                end
            end
            sbd_pkg::OP_PRUNE: begin
                if (threshold != 0) begin
                    kept = 0;
                    for (int i = 0; i < shadow_used; i++) begin
                        if (shadow_occ[i] > {8'd0, threshold}) begin
                            shadow_key[kept] = shadow_key[i];
                            shadow_occ[kept] = shadow_occ[i];
                            kept++;
                        end
                    end
                    if (kept != shadow_used) begin
                        // survivors go to ascending key order
                        for (int i = 1; i < kept; i++) begin
                            k = shadow_key[i];
                            c = shadow_occ[i];
                            j = i;
                            while (j > 0 && shadow_key[j-1] > k) begin
                                shadow_key[j] = shadow_key[j-1];
                                shadow_occ[j] = shadow_occ[j-1];
                                j--;
                            end
                            shadow_key[j] = k;
                            shadow_occ[j] = c;
                        end
                        res.removed = 11'(shadow_used - kept);
                        shadow_used = kept;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (quiet || p < 55) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // Driver: feeds the pending requests, holding each until accepted.
    int unsigned send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                expected_results.push_back(dict_apply('{sbd_pkg::op_t'(s_opcode),
                                                        s_bit_number, s_bit_count,
                                                        s_last_bit}));
                reqs_sent++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_valid <= 1'b1;
                s_opcode <= pending_reqs[0].op;
                s_bit_number <= pending_reqs[0].bitn;
                s_bit_count <= pending_reqs[0].cnt;
                s_last_bit <= pending_reqs[0].last;
                void'(pending_reqs.pop_front());
                send_gap <= gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and in-order comparison.
    int unsigned recv_stall = 0;
    always @(posedge aclk) begin
        dict_result_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got index 0x%0h",
                         $time, m_dense_index);
            end else begin
                e = expected_results.pop_front();
                check_field("dense_index", 32'(e.idx), 32'(m_dense_index));
                check_field("found", 32'(e.found), 32'(m_found));
                check_field("inserted", 32'(e.inserted), 32'(m_inserted));
                check_field("table_full", 32'(e.full), 32'(m_table_full));
                check_field("out_count", 32'(e.out_count), 32'(m_out_count));
                check_field("miss_bits", 32'(e.miss_bits), 32'(m_miss_bits));
                check_field("miss_sum", e.miss_sum, m_miss_sum);
                check_field("removed", 32'(e.removed), 32'(m_removed));
                check_field("fingerprint_done", 32'(e.done), 32'(m_fingerprint_done));
            end
        end
        if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_stall <= gap_len();
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_req(sbd_pkg::op_t op, logic [31:0] b, logic [15:0] c, logic l);
        pending_reqs.push_back('{op, b, c, l});
        reqs_queued++;
    endtask

    // Sender holds off until every expected result has come back.
    task automatic drain();
        do @(posedge aclk);
        while (results_seen != reqs_queued);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        threshold = v;
    endtask

    logic [31:0]  key_pool [48];
    sbd_pkg::op_t rop;
    int unsigned  p;

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, every opcode, unknown totals and fingerprint end.
        queue_req(sbd_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        queue_req(sbd_pkg::OP_CONVERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_req(sbd_pkg::OP_CONVERT, 32'h0, 16'h0, 1'b1);
        queue_req(sbd_pkg::OP_PROFILE, 32'h0, 16'hFFFF, 1'b1);
        queue_req(sbd_pkg::OP_PROFILE, 32'hFFFF_FFFF, 16'h0, 1'b0);
        queue_req(sbd_pkg::OP_PROFILE, 32'h8000_0000, 16'h0, 1'b0);
        queue_req(sbd_pkg::OP_PROFILE, 32'h0, 16'h0, 1'b0);
        queue_req(sbd_pkg::OP_PROFILE, 32'h0000_0001, 16'h0, 1'b0);
        queue_req(sbd_pkg::OP_CONVERT, 32'h0, 16'hFFFF, 1'b0);
        queue_req(sbd_pkg::OP_CONVERT, 32'h1234_5678, 16'hFFFF, 1'b0);
        queue_req(sbd_pkg::OP_CONVERT, 32'hFFFF_FFFF, 16'h1, 1'b1);
        // threshold zero: no-op
        queue_req(sbd_pkg::OP_PRUNE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        write_threshold(16'd1);
        queue_req(sbd_pkg::OP_PRUNE, 32'h0, 16'h0, 1'b0);     // drops count-one entries
        queue_req(sbd_pkg::OP_PROFILE, 32'h0000_0002, 16'h0, 1'b0);
        queue_req(sbd_pkg::OP_CONVERT, 32'h0, 16'h5, 1'b1);
        queue_req(sbd_pkg::OP_PRUNE, 32'h0, 16'h0, 1'b0);     // drops the new count-one entry
        write_threshold(16'd0);

        // Random phases over a small key set so the table stays short.
        for (int i = 0; i < 48; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_threshold(16'd1);
                1: write_threshold(16'($urandom_range(2, 6)));
                2: write_threshold(16'hFFFF);
                default: write_threshold(16'd2);
            endcase
            quiet = (ph == 1);
            for (int n = 0; n < 210; n++) begin
                p = $urandom_range(0, 99);
                rop = p < 48 ? sbd_pkg::OP_PROFILE : p < 90 ? sbd_pkg::OP_CONVERT :
                      p < 97 ? sbd_pkg::OP_PRUNE : sbd_pkg::OP_NONE;
                queue_req(rop, $urandom_range(0, 4) == 0 ? $urandom()
                                                         : key_pool[$urandom_range(0, 47)],
                          16'($urandom()), $urandom_range(0, 3) == 0);
                while (pending_reqs.size() > 8) @(posedge aclk);
            end
        end
        quiet = 1'b0;
        drain();

        $display("Covered %0d requests and %0d results: directed extremes and opcodes,",
                 reqs_sent, results_seen);
        $display("then random profile/convert/prune mixes at four thresholds with stalls.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
